/* sv/qas_pkg.sv */
package qas_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_BSL  = 2'd2,
        KIND_QUOT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } quote_mode_t;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0d;

    typedef struct packed {
        quote_mode_t quote_mode;
        logic        escape_pending;
        logic        word_started;
    } parse_state_t;

    typedef struct packed {
        logic       emit;
        kind_t      kind;
        logic [7:0] word_byte;
    } parse_result_t;

endpackage

/* sv/qas_step.sv */
module qas_step
(
    input  logic [7:0]            text_byte,
    input  qas_pkg::parse_state_t cur_state,
    output qas_pkg::parse_state_t nxt_state,
    output qas_pkg::parse_result_t result
);

    logic               blank;
    logic               is_quote;
    qas_pkg::quote_mode_t hit_mode;

    assign blank = (text_byte == qas_pkg::CHAR_SPACE)
                || (text_byte >= qas_pkg::CHAR_TAB && text_byte <= qas_pkg::CHAR_CR);
    assign is_quote = (text_byte == qas_pkg::CHAR_SQUOTE)
                   || (text_byte == qas_pkg::CHAR_DQUOTE);
    assign hit_mode = (text_byte == qas_pkg::CHAR_SQUOTE) ? qas_pkg::QM_SINGLE
                                                          : qas_pkg::QM_DOUBLE;

    always_comb
    begin
        nxt_state        = cur_state;
        result.emit      = 1'b0;
        result.kind      = qas_pkg::KIND_BYTE;
        result.word_byte = 8'd0;

        if (text_byte == qas_pkg::CHAR_NUL)
        begin
            // end of string: report and return to idle
            nxt_state.quote_mode     = qas_pkg::QM_NONE;
            nxt_state.escape_pending = 1'b0;
            nxt_state.word_started   = 1'b0;
            if (cur_state.escape_pending)
            begin
                result.emit = 1'b1;
                result.kind = qas_pkg::KIND_BSL;
            end
            else if (cur_state.quote_mode != qas_pkg::QM_NONE)
            begin
                result.emit = 1'b1;
                result.kind = qas_pkg::KIND_QUOT;
            end
            else if (cur_state.word_started)
            begin
                result.emit = 1'b1;
                result.kind = qas_pkg::KIND_END;
            end
        end
        else if (cur_state.escape_pending)
        begin
            nxt_state.escape_pending = 1'b0;
            nxt_state.word_started   = 1'b1;
            result.emit              = 1'b1;
            result.word_byte         = text_byte;
        end
        else if (cur_state.quote_mode == qas_pkg::QM_NONE && blank)
        begin
            if (cur_state.word_started)
            begin
                nxt_state.word_started = 1'b0;
                result.emit            = 1'b1;
                result.kind            = qas_pkg::KIND_END;
            end
        end
        else
        begin
            nxt_state.word_started = 1'b1;
            if (text_byte == qas_pkg::CHAR_BACKSLASH
                && cur_state.quote_mode != qas_pkg::QM_SINGLE)
            begin
                nxt_state.escape_pending = 1'b1;
            end
            else if (is_quote && cur_state.quote_mode == qas_pkg::QM_NONE)
            begin
                nxt_state.quote_mode = hit_mode;
            end
            else if (is_quote && cur_state.quote_mode == hit_mode)
            begin
                nxt_state.quote_mode = qas_pkg::QM_NONE;
            end
            else
            begin
                // any other byte is literal, including the other quote kind inside a run
                result.emit      = 1'b1;
                result.word_byte = text_byte;
            end
        end
    end

endmodule

/* sv/quoted_argument_splitter.sv */
// channel   direction  payload
// in        request    text_byte[7:0]
// out       result     kind[1:0], word_byte[7:0]
//
// one byte accepted per cycle while the output is not stalled; a result passes
// through the input register and then the result register.
// the parse state updates as a byte moves from the input register to the
// result register, so a stalled output holds the input register in place.
// rst_n clears the parse state and both valid flags.
module quoted_argument_splitter
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] word_byte
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    qas_pkg::parse_state_t  state_reg;
    qas_pkg::parse_state_t  state_next;
    qas_pkg::parse_result_t step_result;
    logic                   out_valid_reg;
    logic [1:0]             kind_reg;
    logic [7:0]             word_byte_reg;
    logic                   advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    qas_step u_step
    (
        .text_byte (in_byte_reg),
        .cur_state (state_reg),
        .nxt_state (state_next),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            state_reg.quote_mode     <= qas_pkg::QM_NONE;
            state_reg.escape_pending <= 1'b0;
            state_reg.word_started   <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= step_result.emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= text_byte;
        end
        if (advance)
        begin
            kind_reg      <= step_result.kind;
            word_byte_reg <= step_result.word_byte;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign word_byte = word_byte_reg;

endmodule
